### rtl/qsl_pkg.sv
// ============================================================================
// qsl_pkg
// Shared constants and beat types for the quicksort (Lomuto) sorter.
// ============================================================================
package qsl_pkg;

   // Store capacity and element width.
   localparam int MAX_ELEMENTS = 16;
   localparam int DATA_WIDTH   = 32;

   // Index into the element store and a count that can also hold the capacity.
   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   // Input beat: one element of the set.
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last;
   } req_type;

   // Result beat: one element of the sorted set.
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value_res;
      logic                         last_res;
      logic                         overflow;
   } rsp_type;

   // One pending range on the range stack.
   typedef struct packed {
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
   } range_type;

endpackage

### rtl/qsl_store.sv
// ============================================================================
// qsl_store
// Element store: one write port and one read port with registered read data.
// ============================================================================
module qsl_store (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [qsl_pkg::IDX_W-1:0]            wr_addr,
   input  logic signed [qsl_pkg::DATA_WIDTH-1:0] wr_data,
   input  logic                                 rd_en,
   input  logic [qsl_pkg::IDX_W-1:0]            rd_addr,
   output logic signed [qsl_pkg::DATA_WIDTH-1:0] rd_data
);

   logic signed [qsl_pkg::DATA_WIDTH-1:0] mem_ff [qsl_pkg::MAX_ELEMENTS];
   logic signed [qsl_pkg::DATA_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register holds its value while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/qsl_stack.sv
// ============================================================================
// qsl_stack
// Range stack: pending lo/hi pairs in a small memory with a depth pointer.
// ============================================================================
module qsl_stack (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qsl_pkg::range_type   push_data,
   input  logic                 pop,
   output logic                 empty,
   output qsl_pkg::range_type   pop_data
);

   qsl_pkg::range_type              mem_ff [qsl_pkg::MAX_ELEMENTS];
   qsl_pkg::range_type              pop_data_ff;
   logic [qsl_pkg::CNT_W-1:0]       depth_ff;
   logic [qsl_pkg::CNT_W-1:0]       depth_in;
   logic [qsl_pkg::CNT_W-1:0]       top_idx;

   assign top_idx = depth_ff - qsl_pkg::CNT_W'(1);
   assign empty   = (depth_ff == '0);

   // Depth pointer; push and pop never coincide.
   always_comb begin
      depth_in = depth_ff;
      if (push) begin
         depth_in = depth_ff + qsl_pkg::CNT_W'(1);
      end else if (pop) begin
         depth_in = top_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   // Memory: push writes at the pointer, pop reads the entry below it.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[depth_ff[qsl_pkg::IDX_W-1:0]] <= push_data;
      end
      if (pop) begin
         pop_data_ff <= mem_ff[top_idx[qsl_pkg::IDX_W-1:0]];
      end
   end

   assign pop_data = pop_data_ff;

endmodule

### rtl/quicksort_lomuto_sorter.sv
// ============================================================================
// quicksort_lomuto_sorter
// Collects a set of signed values, sorts it with Lomuto quicksort in the
// element store and streams it out in ascending order.
// ============================================================================
// Loading takes a beat whenever start is high and busy is low. Sorting then pops a
// range off the stack (none for the whole set), fetches its pivot, swaps each
// element not greater than the pivot to the mark, places the pivot at the mark and
// pushes each sub-range of two or more elements, the second in a state of its own,
// until it finds the stack empty. The results follow on consecutive cycles; the
// receiver cannot stall. Synchronous reset empties the set and clears the overflow.
module quicksort_lomuto_sorter (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  qsl_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output qsl_pkg::rsp_type  rsp_item
);

   localparam int IW = qsl_pkg::IDX_W;
   localparam int CW = qsl_pkg::CNT_W;
   localparam int DW = qsl_pkg::DATA_WIDTH;

   // Sequencer states.
   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_POP   = 4'd2;
   localparam logic [3:0] S_POPW  = 4'd3;
   localparam logic [3:0] S_PIVG  = 4'd4;
   localparam logic [3:0] S_CMP   = 4'd5;
   localparam logic [3:0] S_SWPA  = 4'd6;
   localparam logic [3:0] S_SWPB  = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;
   localparam logic [3:0] S_FINA  = 4'd9;
   localparam logic [3:0] S_FINB  = 4'd10;
   localparam logic [3:0] S_PUSH2 = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   logic [3:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [IW-1:0]        lo_ff, lo_in;
   logic [IW-1:0]        hi_ff, hi_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        mark_ff, mark_in;
   logic signed [DW-1:0] pivot_ff, pivot_in;
   logic signed [DW-1:0] vi_ff, vi_in;
   logic                 emit_ff, emit_in;
   logic                 emit_last_ff, emit_last_in;
   logic                 emit_ovf_ff, emit_ovf_in;

   // Store and stack port signals.
   logic                 st_we;
   logic [IW-1:0]        st_waddr;
   logic signed [DW-1:0] st_wdata;
   logic                 st_re;
   logic [IW-1:0]        st_raddr;
   logic signed [DW-1:0] st_rdata;
   logic                 stk_push;
   qsl_pkg::range_type   stk_push_data;
   logic                 stk_pop;
   logic                 stk_empty;
   qsl_pkg::range_type   stk_pop_data;

   // Helpers for the partition loop and the pivot placement.
   logic                 accept;
   logic [IW-1:0]        idx_next;
   logic                 at_end;
   logic                 elem_le;
   logic                 push_left;
   logic                 push_right;

   assign accept     = start && (state_ff == S_LOAD);
   assign idx_next   = idx_ff + IW'(1);
   assign at_end     = (idx_next == hi_ff);
   assign elem_le    = (st_rdata <= pivot_ff);
   assign push_left  = {1'b0, mark_ff} > ({1'b0, lo_ff} + CW'(1));
   assign push_right = ({1'b0, mark_ff} + CW'(1)) < {1'b0, hi_ff};

   qsl_store u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   qsl_stack u_stack (
      .clock     (clock),
      .reset     (reset),
      .push      (stk_push),
      .push_data (stk_push_data),
      .pop       (stk_pop),
      .empty     (stk_empty),
      .pop_data  (stk_pop_data)
   );

   // Sequencer: load, partition ranges, then stream the store out.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      idx_in        = idx_ff;
      mark_in       = mark_ff;
      pivot_in      = pivot_ff;
      vi_in         = vi_ff;
      emit_in       = 1'b0;
      emit_last_in  = emit_last_ff;
      emit_ovf_in   = emit_ovf_ff;
      st_we         = 1'b0;
      st_waddr      = idx_ff;
      st_wdata      = vi_ff;
      st_re         = 1'b0;
      st_raddr      = idx_ff;
      stk_push      = 1'b0;
      stk_push_data = '{lo: lo_ff, hi: hi_ff};
      stk_pop       = 1'b0;

      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (count_ff < CW'(qsl_pkg::MAX_ELEMENTS)) begin
                  st_we    = 1'b1;
                  st_waddr = count_ff[IW-1:0];
                  st_wdata = req_item.value;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_item.last) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            // A single element needs no sorting; otherwise sort the whole set.
            if (count_ff < CW'(2)) begin
               idx_in   = '0;
               state_in = S_OUT;
            end else begin
               lo_in    = '0;
               hi_in    = IW'(count_ff - CW'(1));
               st_re    = 1'b1;
               st_raddr = IW'(count_ff - CW'(1));
               state_in = S_PIVG;
            end
         end
         S_POP: begin
            if (stk_empty) begin
               idx_in   = '0;
               state_in = S_OUT;
            end else begin
               stk_pop  = 1'b1;
               state_in = S_POPW;
            end
         end
         S_POPW: begin
            lo_in    = stk_pop_data.lo;
            hi_in    = stk_pop_data.hi;
            st_re    = 1'b1;
            st_raddr = stk_pop_data.hi;
            state_in = S_PIVG;
         end
         S_PIVG: begin
            pivot_in = st_rdata;
            idx_in   = lo_ff;
            mark_in  = lo_ff;
            st_re    = 1'b1;
            st_raddr = lo_ff;
            state_in = S_CMP;
         end
         S_CMP: begin
            // The element at idx is in the read register.
            if (elem_le && (mark_ff != idx_ff)) begin
               vi_in    = st_rdata;
               st_re    = 1'b1;
               st_raddr = mark_ff;
               state_in = S_SWPA;
            end else begin
               if (elem_le) begin
                  mark_in = mark_ff + IW'(1);
               end
               if (at_end) begin
                  state_in = S_FIN;
               end else begin
                  idx_in   = idx_next;
                  st_re    = 1'b1;
                  st_raddr = idx_next;
               end
            end
         end
         S_SWPA: begin
            // Element at mark moves to idx.
            st_we    = 1'b1;
            st_waddr = idx_ff;
            st_wdata = st_rdata;
            state_in = S_SWPB;
         end
         S_SWPB: begin
            st_we    = 1'b1;
            st_waddr = mark_ff;
            st_wdata = vi_ff;
            mark_in  = mark_ff + IW'(1);
            if (at_end) begin
               state_in = S_FIN;
            end else begin
               idx_in   = idx_next;
               st_re    = 1'b1;
               st_raddr = idx_next;
               state_in = S_CMP;
            end
         end
         S_FIN: begin
            st_re    = 1'b1;
            st_raddr = mark_ff;
            state_in = S_FINA;
         end
         S_FINA: begin
            st_we    = 1'b1;
            st_waddr = hi_ff;
            st_wdata = st_rdata;
            state_in = S_FINB;
         end
         S_FINB: begin
            // Pivot lands at mark; push the sub-ranges of two or more elements.
            st_we    = 1'b1;
            st_waddr = mark_ff;
            st_wdata = pivot_ff;
            state_in = S_POP;
            if (push_left) begin
               stk_push      = 1'b1;
               stk_push_data = '{lo: lo_ff, hi: mark_ff - IW'(1)};
               if (push_right) begin
                  state_in = S_PUSH2;
               end
            end else if (push_right) begin
               stk_push      = 1'b1;
               stk_push_data = '{lo: mark_ff + IW'(1), hi: hi_ff};
            end
         end
         S_PUSH2: begin
            stk_push      = 1'b1;
            stk_push_data = '{lo: mark_ff + IW'(1), hi: hi_ff};
            state_in      = S_POP;
         end
         S_OUT: begin
            st_re        = 1'b1;
            st_raddr     = idx_ff;
            emit_in      = 1'b1;
            emit_ovf_in  = ovf_ff;
            emit_last_in = ({1'b0, idx_ff} == (count_ff - CW'(1)));
            if ({1'b0, idx_ff} == (count_ff - CW'(1))) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = S_LOAD;
            end else begin
               idx_in = idx_next;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         emit_ff  <= emit_in;
      end
   end

   // Working registers of the partition and the result flags.
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      idx_ff       <= idx_in;
      mark_ff      <= mark_in;
      pivot_ff     <= pivot_in;
      vi_ff        <= vi_in;
      emit_last_ff <= emit_last_in;
      emit_ovf_ff  <= emit_ovf_in;
   end

   assign busy                = (state_ff != S_LOAD);
   assign rsp_strobe          = emit_ff;
   assign rsp_item.value_res  = st_rdata;
   assign rsp_item.last_res   = emit_last_ff;
   assign rsp_item.overflow   = emit_ovf_ff;

endmodule

### rtl/qsl_checker.sv
// ============================================================================
// qsl_checker
// Port-level checks on the sorter's command and result timing.
// ============================================================================
module qsl_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input qsl_pkg::req_type  req_item,
   input logic              rsp_strobe,
   input qsl_pkg::rsp_type  rsp_item
);

   // A set that ends must make the block busy in the next cycle.
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.last |=> busy)
      else $error("sorter not busy after the final input beat");

   // Only the final result beat may be shown once the block is idle again.
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !busy |-> rsp_item.last_res)
      else $error("non-final result beat while idle");

   // Results stream on consecutive cycles until the final one.
   a_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last_res |=> rsp_strobe)
      else $error("gap in the result stream");

   // The overflow mark is the same on every result beat of a set.
   a_ovf_const: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last_res |=> $stable(rsp_item.overflow))
      else $error("overflow mark changed within a set");

   // After reset the block is idle and shows no result.
   a_reset: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("sorter not idle after reset");

endmodule

bind quicksort_lomuto_sorter qsl_checker u_qsl_checker (.*);

### tb/quicksort_lomuto_sorter_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// quicksort_lomuto_sorter_tb
// Self-checking bench for the quicksort sorter. Sets of signed values are fed
// in through the start/busy command port. A local Lomuto quicksort predicts
// each sorted set, and every result beat is checked against the oldest
// prediction. Sets cover single elements, extremes, duplicates, a full store
// and sets that overrun the store.
// ============================================================================
module quicksort_lomuto_sorter_tb;

   typedef logic signed [qsl_pkg::DATA_WIDTH-1:0] elem_type;

   // One queued input beat; drain_first holds it back until every result due
   // so far has come out.
   typedef struct {
      qsl_pkg::req_type beat;
      bit               drain_first;
   } queued_beat_type;

   localparam int CYCLE_LIMIT = 200000;
   localparam elem_type ELEM_MAX = {1'b0, {(qsl_pkg::DATA_WIDTH-1){1'b1}}};
   localparam elem_type ELEM_MIN = {1'b1, {(qsl_pkg::DATA_WIDTH-1){1'b0}}};

   logic             clock;
   logic             reset;
   logic             start = 1'b0;
   logic             busy;
   qsl_pkg::req_type req_item = '0;
   logic             rsp_strobe;
   qsl_pkg::rsp_type rsp_item;

   // Stimulus and scoreboard state.
   queued_beat_type  beat_queue[$];
   qsl_pkg::rsp_type sorted_due[$];
   int               results_due = 0;
   int               results_seen = 0;
   int               mismatch_count = 0;
   int               beats_sent = 0;
   int               sets_built = 0;
   int               overrun_sets = 0;
   int               cycle_count = 0;
   int               burst_left;
   int               gap_left;

   // Local copy of the sorter's set.
   elem_type held_values[qsl_pkg::MAX_ELEMENTS];
   int       held_count = 0;
   bit       dropped_flag = 1'b0;

   quicksort_lomuto_sorter DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Lomuto quicksort over the first n held values, with an explicit range
   // stack in place of recursion.
   function automatic void lomuto_sort(int n);
      int       lo_stack[qsl_pkg::MAX_ELEMENTS];
      int       hi_stack[qsl_pkg::MAX_ELEMENTS];
      int       depth;
      int       lo;
      int       hi;
      int       mark;
      elem_type pivot;
      elem_type tmp;
      if (n < 2) return;
      lo_stack[0] = 0;
      hi_stack[0] = n - 1;
      depth = 1;
      while (depth > 0) begin
         depth--;
         lo = lo_stack[depth];
         hi = hi_stack[depth];
         if (lo >= hi) continue;
         pivot = held_values[hi];
         mark = lo;
         for (int i = lo; i < hi; i++) begin
            if (held_values[i] <= pivot) begin
               tmp = held_values[i];
               held_values[i] = held_values[mark];
               held_values[mark] = tmp;
               mark++;
            end
         end
         tmp = held_values[mark];
         held_values[mark] = held_values[hi];
         held_values[hi] = tmp;
         if (mark - 1 > lo && depth < qsl_pkg::MAX_ELEMENTS) begin
            lo_stack[depth] = lo;
            hi_stack[depth] = mark - 1;
            depth++;
         end
         if (mark + 1 < hi && depth < qsl_pkg::MAX_ELEMENTS) begin
            lo_stack[depth] = mark + 1;
            hi_stack[depth] = hi;
            depth++;
         end
      end
   endfunction

   // Store an accepted beat; on the closing beat sort the set and queue the
   // sorted results.
   function automatic void take_beat(qsl_pkg::req_type beat);
      qsl_pkg::rsp_type res;
      if (held_count < qsl_pkg::MAX_ELEMENTS) begin
         held_values[held_count] = beat.value;
         held_count++;
      end else begin
         dropped_flag = 1'b1;
      end
      if (beat.last) begin
         lomuto_sort(held_count);
         for (int k = 0; k < held_count; k++) begin
            res.value_res = held_values[k];
            res.last_res  = (k == held_count - 1);
            res.overflow  = dropped_flag;
            sorted_due.insert(sorted_due.size(), res);
         end
         results_due += held_count;
         held_count = 0;
         dropped_flag = 1'b0;
      end
   endfunction

   // Element values: full range, a narrow band for duplicates, or extremes.
   function automatic elem_type pick_value();
      elem_type v;
      case ($urandom_range(0, 3))
         0: v = elem_type'($urandom_range(0, 6)) - elem_type'(3);
         1: begin
            case ($urandom_range(0, 3))
               0: v = ELEM_MAX;
               1: v = ELEM_MIN;
               2: v = '0;
               default: v = '1;
            endcase
         end
         default: v = elem_type'({$urandom, $urandom});
      endcase
      return v;
   endfunction

   // Queue a whole set; the final beat carries the last mark.
   function automatic void queue_set(int size, bit drain);
      queued_beat_type qb;
      for (int i = 0; i < size; i++) begin
         qb.beat.value = pick_value();
         qb.beat.last  = (i == size - 1);
         qb.drain_first = drain && (i == 0);
         beat_queue.insert(beat_queue.size(), qb);
      end
      sets_built++;
      if (size > qsl_pkg::MAX_ELEMENTS) overrun_sets++;
   endfunction

   function automatic void queue_fixed(elem_type value, bit last, bit drain);
      queued_beat_type qb;
      qb.beat.value  = value;
      qb.beat.last   = last;
      qb.drain_first = drain;
      beat_queue.insert(beat_queue.size(), qb);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Driver: a beat is taken at an edge with start high and busy low. The
   // sender works in bursts with random gaps between them.
   always @(posedge clock) begin
      queued_beat_type qb;
      if (reset) begin
         start      <= 1'b0;
         req_item   <= '0;
         burst_left = $urandom_range(1, 12);
         gap_left   = 0;
      end else begin
         if (start && !busy) begin
            take_beat(req_item);
            beats_sent++;
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (beat_queue.size() == 0) begin
               start <= 1'b0;
            end else if (beat_queue[0].drain_first && results_seen != results_due) begin
               start <= 1'b0;
            end else begin
               qb = beat_queue.pop_front();
               req_item <= qb.beat;
               start    <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // Monitor: every strobed result beat is checked against the oldest
   // prediction.
   always @(posedge clock) begin
      qsl_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         results_seen <= results_seen + 1;
         if (sorted_due.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_item), '0);
         end else begin
            want = sorted_due.pop_front();
            if (rsp_item.value_res !== want.value_res)
               report_mismatch("value_res", 64'(rsp_item.value_res), 64'(want.value_res));
            if (rsp_item.last_res !== want.last_res)
               report_mismatch("last_res", 64'(rsp_item.last_res), 64'(want.last_res));
            if (rsp_item.overflow !== want.overflow)
               report_mismatch("overflow", 64'(rsp_item.overflow), 64'(want.overflow));
         end
      end
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      int size;
      int random_beats;
      // Single-element sets at both extremes.
      queue_fixed(ELEM_MAX, 1'b1, 1'b0);
      queue_fixed(ELEM_MIN, 1'b1, 1'b0);
      // Extremes and values around zero in one set.
      queue_fixed(ELEM_MIN, 1'b0, 1'b0);
      queue_fixed(ELEM_MAX, 1'b0, 1'b0);
      queue_fixed('0, 1'b0, 1'b0);
      queue_fixed('1, 1'b0, 1'b0);
      queue_fixed(elem_type'(1), 1'b1, 1'b0);
      // All values equal.
      for (int i = 0; i < 3; i++) queue_fixed(elem_type'(7), i == 2, 1'b0);
      // Overrun by one beat, where the dropped beat carries the last mark.
      for (int i = 0; i <= qsl_pkg::MAX_ELEMENTS; i++) begin
         if (i == 0) queue_fixed(ELEM_MAX, 1'b0, 1'b0);
         else if (i == 8) queue_fixed(ELEM_MIN, 1'b0, 1'b0);
         else queue_fixed(elem_type'(1000 - 150 * i), i == qsl_pkg::MAX_ELEMENTS, 1'b0);
      end
      sets_built   = 5;
      overrun_sets = 1;
      // Random sets, mostly in range, some full and some overrunning.
      random_beats = 0;
      while (random_beats < 90) begin
         case ($urandom_range(0, 9))
            0: size = 1;
            1: size = qsl_pkg::MAX_ELEMENTS;
            2: size = $urandom_range(qsl_pkg::MAX_ELEMENTS + 1, qsl_pkg::MAX_ELEMENTS + 4);
            default: size = $urandom_range(2, qsl_pkg::MAX_ELEMENTS - 1);
         endcase
         queue_set(size, random_beats == 0 || $urandom_range(0, 3) == 0);
         random_beats += size;
      end

      @(negedge reset);
      do @(posedge clock);
      while (beat_queue.size() != 0 || start || results_seen != results_due);
      repeat (40) @(posedge clock);
      if (sorted_due.size() != 0)
         report_mismatch("results never seen", 64'(sorted_due.size()), '0);

      $display("Sent %0d beats in %0d sets, %0d of them past capacity.",
               beats_sent, sets_built, overrun_sets);
      $display("Checked %0d sorted result beats.", results_seen);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
rtl/qsl_pkg.sv
rtl/qsl_store.sv
rtl/qsl_stack.sv
rtl/quicksort_lomuto_sorter.sv
rtl/qsl_checker.sv
tb/quicksort_lomuto_sorter_tb.sv
